### hdl/fdsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsg_pkg
// Shared constants and controller/datapath interface types for the filled
// disc span generator.
// ----------------------------------------------------------------------------
package fdsg_pkg;

    localparam int COORD_BITS = 12;
    localparam int RAD_BITS   = 5;
    localparam int MAX_RADIUS = 31;
    localparam int OUT_BITS   = 14;
    localparam int DY_BITS    = RAD_BITS + 1;
    localparam int N_BITS     = 2 * RAD_BITS;
    localparam int ROOT_BITS  = RAD_BITS;
    localparam int BIT_IDX_W  = $clog2(ROOT_BITS);

    typedef struct packed {
        logic load;
        logic calc;
        logic root_step;
        logic round;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic empty_mark;
        logic root_done;
        logic last_row;
        logic out_free;
    } dp_status_t;

endpackage

### hdl/fdsg_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsg_controller
// Sequencer that steps each mark through its rows: square operand, bit
// serial root, rounding and span write.
// ----------------------------------------------------------------------------
module fdsg_controller
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 mark_valid,
    output logic                 mark_stall,
    input  fdsg_pkg::dp_status_t status,
    output fdsg_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_ROOT,
        S_ROUND,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (mark_valid)
                begin
                    cmd.load = 1'b1;
                    if (!status.empty_mark)
                    begin
                        state_next = S_CALC;
                    end
                end
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.root_done)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.last_row ? S_IDLE : S_CALC;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign mark_stall = (state_reg != S_IDLE);

endmodule

### hdl/fdsg_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsg_datapath
// Mark registers, row counter, bit serial rounded square root and the
// span output register.
// ----------------------------------------------------------------------------
module fdsg_datapath
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [fdsg_pkg::COORD_BITS-1:0]        center_x,
    input  logic [fdsg_pkg::COORD_BITS-1:0]        center_y,
    input  logic [fdsg_pkg::RAD_BITS-1:0]          radius,
    input  logic                                   is_point,
    input  fdsg_pkg::dp_cmd_t                      cmd,
    output fdsg_pkg::dp_status_t                   status,
    output logic                                   span_valid,
    input  logic                                   span_stall,
    output logic signed [fdsg_pkg::OUT_BITS-1:0]   span_row,
    output logic signed [fdsg_pkg::OUT_BITS-1:0]   span_first,
    output logic signed [fdsg_pkg::OUT_BITS-1:0]   span_final,
    output logic                                   last_span
);

    localparam int CB = fdsg_pkg::COORD_BITS;
    localparam int RB = fdsg_pkg::RAD_BITS;
    localparam int DB = fdsg_pkg::DY_BITS;
    localparam int NB = fdsg_pkg::N_BITS;
    localparam int KB = fdsg_pkg::ROOT_BITS;
    localparam int IB = fdsg_pkg::BIT_IDX_W;
    localparam int OB = fdsg_pkg::OUT_BITS;

    logic [CB-1:0]        cx_reg;
    logic [CB-1:0]        cy_reg;
    logic [RB-1:0]        r_reg;
    logic                 point_reg;
    logic signed [DB-1:0] dy_reg;
    logic [NB-1:0]        n_reg;
    logic [KB-1:0]        root_reg;
    logic [IB-1:0]        bit_idx_reg;
    logic [KB:0]          h_reg;

    logic                 out_valid_reg;
    logic signed [OB-1:0] row_reg;
    logic signed [OB-1:0] first_reg;
    logic signed [OB-1:0] final_reg;
    logic                 last_reg;

    logic [RB-1:0]        r_sat;
    logic signed [DB-1:0] dy_last;
    logic [RB-1:0]        ady;
    logic [NB-1:0]        n_next;
    logic [KB-1:0]        trial;
    logic [NB-1:0]        trial_sq;
    logic [NB:0]          pronic;
    logic [KB:0]          h_next;
    logic signed [OB-1:0] cx_ext;
    logic signed [OB-1:0] cy_ext;
    logic signed [OB-1:0] dy_ext;
    logic signed [OB-1:0] h_ext;

    assign r_sat   = (radius > RB'(fdsg_pkg::MAX_RADIUS)) ? RB'(fdsg_pkg::MAX_RADIUS) : radius;
    assign dy_last = signed'({1'b0, r_reg - RB'(1)});
    assign ady     = dy_reg[DB-1] ? RB'(-dy_reg) : RB'(dy_reg);
    assign n_next  = (NB'(r_reg) * NB'(r_reg)) - (NB'(ady) * NB'(ady));

    assign trial    = root_reg | (KB'(1) << bit_idx_reg);
    assign trial_sq = NB'(trial) * NB'(trial);
    assign pronic   = (NB + 1)'(root_reg) * ((NB + 1)'(root_reg) + (NB + 1)'(1));
    assign h_next   = point_reg ? (KB + 1)'(1)
                    : (((NB + 1)'(n_reg) > pronic) ? ({1'b0, root_reg} + (KB + 1)'(1))
                                                   : {1'b0, root_reg});

    assign cx_ext = signed'(OB'(cx_reg));
    assign cy_ext = signed'(OB'(cy_reg));
    assign dy_ext = signed'({{(OB - DB){dy_reg[DB-1]}}, dy_reg});
    assign h_ext  = signed'(OB'(h_reg));

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg    <= center_x;
            cy_reg    <= center_y;
            r_reg     <= r_sat;
            point_reg <= is_point;
            dy_reg    <= is_point ? DB'(0) : (DB'(0) - DB'(r_sat - RB'(1)));
        end
        if (cmd.calc)
        begin
            n_reg       <= n_next;
            root_reg    <= '0;
            bit_idx_reg <= IB'(KB - 1);
        end
        if (cmd.root_step)
        begin
            if (trial_sq <= n_reg)
            begin
                root_reg <= trial;
            end
            bit_idx_reg <= bit_idx_reg - IB'(1);
        end
        if (cmd.round)
        begin
            h_reg <= h_next;
        end
        if (cmd.emit)
        begin
            dy_reg    <= dy_reg + DB'(1);
            row_reg   <= cy_ext + dy_ext;
            first_reg <= cx_ext - h_ext + OB'(1);
            final_reg <= cx_ext + h_ext - OB'(1);
            last_reg  <= status.last_row;
        end
    end

    // output transaction valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!span_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.empty_mark = !is_point && (radius == RB'(0));
    assign status.root_done  = (bit_idx_reg == IB'(0));
    assign status.last_row   = point_reg || (dy_reg == dy_last);
    assign status.out_free   = !out_valid_reg || !span_stall;

    assign span_valid = out_valid_reg;
    assign span_row   = row_reg;
    assign span_first = first_reg;
    assign span_final = final_reg;
    assign last_span  = last_reg;

endmodule

### hdl/filled_disc_span_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filled_disc_span_generator
// Turns one mark (centre, radius, point flag) into horizontal spans of a
// filled disc, one span per row, top row first.
// ----------------------------------------------------------------------------
// A mark is taken only while the block is idle. A point mark gives one span;
// a disc of radius r gives 2r-1 spans, each made in turn by operand square,
// five steps of the bit serial square root unit, rounding and output write,
// and the block takes no new mark until the last span of the mark is
// written; a zero radius disc gives nothing. Spans sit in an output
// register, so the next row is computed while a span waits on span_stall.
// Spans are not clipped.
module filled_disc_span_generator
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  mark_valid,
    output logic                                  mark_stall,
    input  logic [fdsg_pkg::COORD_BITS-1:0]       center_x,
    input  logic [fdsg_pkg::COORD_BITS-1:0]       center_y,
    input  logic [fdsg_pkg::RAD_BITS-1:0]         radius,
    input  logic                                  is_point,
    output logic                                  span_valid,
    input  logic                                  span_stall,
    output logic signed [fdsg_pkg::OUT_BITS-1:0]  span_row,
    output logic signed [fdsg_pkg::OUT_BITS-1:0]  span_first,
    output logic signed [fdsg_pkg::OUT_BITS-1:0]  span_final,
    output logic                                  last_span
);

    fdsg_pkg::dp_cmd_t    cmd;
    fdsg_pkg::dp_status_t status;

    fdsg_controller u_controller
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .mark_valid (mark_valid),
        .mark_stall (mark_stall),
        .status     (status),
        .cmd        (cmd)
    );

    fdsg_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius     (radius),
        .is_point   (is_point),
        .cmd        (cmd),
        .status     (status),
        .span_valid (span_valid),
        .span_stall (span_stall),
        .span_row   (span_row),
        .span_first (span_first),
        .span_final (span_final),
        .last_span  (last_span)
    );

endmodule
